>>> src/isl_pkg.sv
// Shared types, constants and codes for the indexed shift list.
package isl_pkg;

    localparam int unsigned LIST_DEPTH = 16;
    localparam int unsigned IDX_W      = $clog2(LIST_DEPTH);
    localparam int unsigned LEN_W      = $clog2(LIST_DEPTH + 1);
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned OPC_W      = 3;
    localparam int unsigned POS_W      = 5;
    localparam int unsigned CNT_W      = 5;
    localparam int unsigned STS_W      = 2;
    localparam int unsigned CMP_W      = (POS_W > LEN_W) ? POS_W : LEN_W;

    typedef enum logic [OPC_W-1:0] {
        OP_APPEND   = 3'd0,
        OP_INSERT   = 3'd1,
        OP_REMOVE   = 3'd2,
        OP_GET      = 3'd3,
        OP_POP_LAST = 3'd4,
        OP_POP_AT   = 3'd5
    } op_t;

    typedef enum logic [STS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic [IDX_W-1:0]         pos;
        logic signed [WORD_W-1:0] word;
    } cmd_t;

endpackage

>>> src/isl_if.sv
// Valid/ready channel interfaces for the request and response transactions.
interface isl_in_if;
    logic                                     valid;
    logic                                     ready;
    logic [isl_pkg::OPC_W-1:0]                opcode;
    logic [isl_pkg::POS_W-1:0]                position;
    logic signed [isl_pkg::WORD_W-1:0]        word_in;

    modport source (output valid, output opcode, output position, output word_in,
                    input ready);
    modport sink   (input valid, input opcode, input position, input word_in,
                    output ready);
endinterface

interface isl_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [isl_pkg::WORD_W-1:0]        word_out;
    logic [isl_pkg::CNT_W-1:0]                count;
    logic [isl_pkg::STS_W-1:0]                status;

    modport source (output valid, output word_out, output count, output status,
                    input ready);
    modport sink   (input valid, input word_out, input count, input status,
                    output ready);
endinterface

>>> src/isl_cell.sv
// One storage cell of the list row: holds, loads the new word or shifts from a neighbor.
module isl_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  isl_pkg::cmd_t                        cmd,
    input  logic signed [isl_pkg::WORD_W-1:0]    left_word,
    input  logic signed [isl_pkg::WORD_W-1:0]    right_word,
    output logic signed [isl_pkg::WORD_W-1:0]    word
);

    localparam logic [isl_pkg::IDX_W-1:0] SLOT = isl_pkg::IDX_W'(INDEX);

    logic signed [isl_pkg::WORD_W-1:0] word_reg;
    logic signed [isl_pkg::WORD_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (en && cmd.ins && (SLOT >= cmd.pos))
        begin
            word_next = (SLOT == cmd.pos) ? cmd.word : left_word;
        end
        else if (en && cmd.rem && (SLOT >= cmd.pos))
        begin
            word_next = right_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

>>> src/isl_ctrl.sv
// Operation decoder: checks bounds and derives the row command, read select and new length.
module isl_ctrl (
    input  logic [isl_pkg::OPC_W-1:0]            opcode,
    input  logic [isl_pkg::POS_W-1:0]            position,
    input  logic signed [isl_pkg::WORD_W-1:0]    word_in,
    input  logic [isl_pkg::LEN_W-1:0]            len,
    output isl_pkg::cmd_t                        cmd,
    output logic                                 rd_en,
    output logic [isl_pkg::IDX_W-1:0]            rd_addr,
    output logic [isl_pkg::LEN_W-1:0]            new_len,
    output isl_pkg::status_t                     status
);

    logic [isl_pkg::CMP_W-1:0] pos_c;
    logic [isl_pkg::CMP_W-1:0] len_c;
    logic                      full;
    logic                      empty;
    logic [isl_pkg::LEN_W-1:0] len_dec;

    assign pos_c   = isl_pkg::CMP_W'(position);
    assign len_c   = isl_pkg::CMP_W'(len);
    assign full    = (len >= isl_pkg::LEN_W'(isl_pkg::LIST_DEPTH));
    assign empty   = (len == '0);
    assign len_dec = len - isl_pkg::LEN_W'(1);

    always_comb
    begin
        cmd.ins  = 1'b0;
        cmd.rem  = 1'b0;
        cmd.pos  = pos_c[isl_pkg::IDX_W-1:0];
        cmd.word = word_in;
        rd_en    = 1'b0;
        rd_addr  = pos_c[isl_pkg::IDX_W-1:0];
        new_len  = len;
        status   = isl_pkg::ST_OK;

        unique case (isl_pkg::op_t'(opcode)) inside
            isl_pkg::OP_APPEND:
            begin
                if (full)
                begin
                    status = isl_pkg::ST_FULL;
                end
                else
                begin
                    cmd.ins = 1'b1;
                    cmd.pos = len[isl_pkg::IDX_W-1:0];
                    new_len = len + isl_pkg::LEN_W'(1);
                end
            end
            isl_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    status = isl_pkg::ST_FULL;
                end
                else if (pos_c > len_c)
                begin
                    status = isl_pkg::ST_RANGE;
                end
                else
                begin
                    cmd.ins = 1'b1;
                    new_len = len + isl_pkg::LEN_W'(1);
                end
            end
            isl_pkg::OP_REMOVE, isl_pkg::OP_GET, isl_pkg::OP_POP_AT:
            begin
                if (empty)
                begin
                    status = isl_pkg::ST_EMPTY;
                end
                else if (pos_c >= len_c)
                begin
                    status = isl_pkg::ST_RANGE;
                end
                else if (isl_pkg::op_t'(opcode) == isl_pkg::OP_GET)
                begin
                    rd_en = 1'b1;
                end
                else
                begin
                    cmd.rem = 1'b1;
                    rd_en   = (isl_pkg::op_t'(opcode) == isl_pkg::OP_POP_AT);
                    new_len = len_dec;
                end
            end
            isl_pkg::OP_POP_LAST:
            begin
                if (empty)
                begin
                    status = isl_pkg::ST_EMPTY;
                end
                else
                begin
                    cmd.rem = 1'b1;
                    cmd.pos = len_dec[isl_pkg::IDX_W-1:0];
                    rd_en   = 1'b1;
                    rd_addr = len_dec[isl_pkg::IDX_W-1:0];
                    new_len = len_dec;
                end
            end
            default:
            begin
                status = isl_pkg::ST_OK;
            end
        endcase
    end

endmodule

>>> src/indexed_shift_list.sv
// Top level of the indexed shift list: length register, cell row and response register.
//
// The block keeps an ordered list of up to 16 signed 32-bit words. A request
// transaction carries an opcode, a position and a word; every request yields
// exactly one response transaction with the word read, the new length and a
// status code. Both channels use a valid/ready handshake.
// The list lives in a row of cells; each cell holds one entry and loads from
// its left or right neighbor, so an insert or remove moves every later entry
// in the same cycle. A request is decoded and applied in the cycle it is
// accepted, and its response is valid from the next cycle on; one request
// is taken every cycle as long as responses are taken.
// The response register gates the request side: when the receiver stalls,
// the pending response holds and a new request is accepted in the same cycle
// that the pending response is taken.
// Reset empties the list and drops any pending response; the cell contents
// are not cleared, since no entry at or above the length is ever read.
module indexed_shift_list (
    input  logic      clk,
    input  logic      rst_n,
    isl_in_if.sink    request,
    isl_out_if.source response
);

    isl_pkg::cmd_t                     cmd;
    logic                              rd_en;
    logic [isl_pkg::IDX_W-1:0]         rd_addr;
    logic [isl_pkg::LEN_W-1:0]         new_len;
    isl_pkg::status_t                  status;
    logic                              accept;
    logic signed [isl_pkg::WORD_W-1:0] cell_word [isl_pkg::LIST_DEPTH];

    logic [isl_pkg::LEN_W-1:0]         len_reg;
    logic [isl_pkg::LEN_W-1:0]         len_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic signed [isl_pkg::WORD_W-1:0] out_word_reg;
    logic signed [isl_pkg::WORD_W-1:0] out_word_next;
    isl_pkg::status_t                  out_status_reg;
    isl_pkg::status_t                  out_status_next;

    isl_ctrl u_ctrl (
        .opcode   (request.opcode),
        .position (request.position),
        .word_in  (request.word_in),
        .len      (len_reg),
        .cmd      (cmd),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .new_len  (new_len),
        .status   (status)
    );

    for (genvar i = 0; i < isl_pkg::LIST_DEPTH; i++)
    begin : g_cell
        logic signed [isl_pkg::WORD_W-1:0] left_word;
        logic signed [isl_pkg::WORD_W-1:0] right_word;

        if (i == 0)
        begin : g_first
            assign left_word = cmd.word;
        end
        else
        begin : g_left
            assign left_word = cell_word[i-1];
        end

        if (i == isl_pkg::LIST_DEPTH - 1)
        begin : g_last
            assign right_word = cell_word[i];
        end
        else
        begin : g_right
            assign right_word = cell_word[i+1];
        end

        isl_cell #(
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .en         (accept),
            .cmd        (cmd),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (cell_word[i])
        );
    end

    assign request.ready = !out_valid_reg || response.ready;
    assign accept        = request.valid && request.ready;

    always_comb
    begin
        len_next        = len_reg;
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        out_status_next = out_status_reg;
        if (accept)
        begin
            len_next        = new_len;
            out_valid_next  = 1'b1;
            out_word_next   = rd_en ? cell_word[rd_addr] : '0;
            out_status_next = status;
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg   <= out_word_next;
        out_status_reg <= out_status_next;
    end

    assign response.valid    = out_valid_reg;
    assign response.word_out = out_word_reg;
    assign response.count    = isl_pkg::CNT_W'(len_reg);
    assign response.status   = out_status_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= isl_pkg::LEN_W'(isl_pkg::LIST_DEPTH))
        else $error("List length exceeds the store depth.");

    a_len_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(len_reg))
        else $error("List length changed without a request transaction.");

    a_accept_resp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("Accepted request produced no response.");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == isl_pkg::ST_FULL)
        |-> (len_reg == isl_pkg::LEN_W'(isl_pkg::LIST_DEPTH)))
        else $error("Full status reported on a list that is not full.");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == isl_pkg::ST_EMPTY)
        |-> (len_reg == '0 && out_word_reg == '0))
        else $error("Empty status reported on a list that is not empty.");

endmodule

>>> bench/testbench.sv
// Self-checking bench for indexed_shift_list: a directed table, then random transactions.
module testbench;
    import isl_pkg::*;

    localparam logic [OPC_W-1:0]         OP_UNUSED_A      = 3'd6;
    localparam logic [OPC_W-1:0]         OP_UNUSED_B      = 3'd7;
    localparam logic signed [WORD_W-1:0] WORD_MIN         = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_MAX         = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_ONES        = 32'shFFFF_FFFF;
    localparam int                       RANDOM_PER_PHASE = 505;
    localparam int                       STALL_LIMIT      = 2000;
    localparam int                       DRAIN_CYCLES     = 4;
    localparam int                       MAX_PRINTED      = 200;

    typedef struct packed {
        logic signed [WORD_W-1:0] word;
        logic [CNT_W-1:0]         count;
        status_t                  status;
    } list_result_t;

    typedef struct {
        logic [OPC_W-1:0]         opc;
        logic [POS_W-1:0]         pos;
        logic signed [WORD_W-1:0] word;
        int                       reps;
        bit                       typed;
        list_result_t             want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    isl_in_if  req_ch ();
    isl_out_if rsp_ch ();

    indexed_shift_list DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch)
    );

    logic signed [WORD_W-1:0] list_words [LIST_DEPTH];
    int unsigned              list_len = 0;
    list_result_t             pending_results [$];
    int                       error_count = 0;
    int                       src_idle_pct = 0;
    int                       rcv_idle_pct = 0;

    // Repeated rows take a fresh random word for every transaction.
    stim_row_t directed_rows [24] = '{
        '{OP_POP_LAST, 5'd0,  32'sd0,          1,  1'b1, '{32'sd0, 5'd0,  ST_EMPTY}},
        '{OP_GET,      5'd0,  32'sd0,          1,  1'b1, '{32'sd0, 5'd0,  ST_EMPTY}},
        '{OP_REMOVE,   5'd31, 32'sd0,          1,  1'b1, '{32'sd0, 5'd0,  ST_EMPTY}},
        '{OP_POP_AT,   5'd0,  32'sd0,          1,  1'b1, '{32'sd0, 5'd0,  ST_EMPTY}},
        '{OP_INSERT,   5'd1,  32'sd5,          1,  1'b1, '{32'sd0, 5'd0,  ST_RANGE}},
        '{OP_UNUSED_A, 5'd0,  32'sd0,          1,  1'b1, '{32'sd0, 5'd0,  ST_OK}},
        '{OP_INSERT,   5'd0,  WORD_MIN,        1,  1'b1, '{32'sd0, 5'd1,  ST_OK}},
        '{OP_APPEND,   5'd0,  WORD_MAX,        1,  1'b1, '{32'sd0, 5'd2,  ST_OK}},
        '{OP_INSERT,   5'd1,  WORD_ONES,       1,  1'b1, '{32'sd0, 5'd3,  ST_OK}},
        '{OP_GET,      5'd2,  32'sd0,          1,  1'b1, '{WORD_MAX, 5'd3, ST_OK}},
        '{OP_GET,      5'd3,  32'sd0,          1,  1'b1, '{32'sd0, 5'd3,  ST_RANGE}},
        '{OP_UNUSED_B, 5'd31, WORD_ONES,       1,  1'b1, '{32'sd0, 5'd3,  ST_OK}},
        '{OP_APPEND,   5'd0,  32'sd0,          13, 1'b0, '{32'sd0, 5'd0,  ST_OK}},
        '{OP_APPEND,   5'd0,  32'sd7,          1,  1'b1, '{32'sd0, 5'd16, ST_FULL}},
        '{OP_INSERT,   5'd31, 32'sd7,          1,  1'b1, '{32'sd0, 5'd16, ST_FULL}},
        '{OP_INSERT,   5'd0,  32'sd7,          1,  1'b1, '{32'sd0, 5'd16, ST_FULL}},
        '{OP_REMOVE,   5'd16, 32'sd0,          1,  1'b1, '{32'sd0, 5'd16, ST_RANGE}},
        '{OP_POP_AT,   5'd15, 32'sd0,          1,  1'b0, '{32'sd0, 5'd0,  ST_OK}},
        '{OP_REMOVE,   5'd0,  32'sd0,          1,  1'b0, '{32'sd0, 5'd0,  ST_OK}},
        '{OP_POP_AT,   5'd0,  32'sd0,          1,  1'b0, '{32'sd0, 5'd0,  ST_OK}},
        '{OP_POP_LAST, 5'd0,  32'sd0,          1,  1'b0, '{32'sd0, 5'd0,  ST_OK}},
        '{OP_INSERT,   5'd12, 32'sh5A5A_5A5A,  1,  1'b0, '{32'sd0, 5'd0,  ST_OK}},
        '{OP_INSERT,   5'd14, 32'sd0,          1,  1'b1, '{32'sd0, 5'd13, ST_RANGE}},
        '{OP_GET,      5'd0,  32'sd0,          1,  1'b0, '{32'sd0, 5'd0,  ST_OK}}
    };

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic signed [WORD_W-1:0] drop_entry(input int unsigned slot);
        logic signed [WORD_W-1:0] taken;
        int unsigned              k;
        taken = list_words[slot];
        for (k = slot; k + 1 < list_len; k++)
            list_words[k] = list_words[k + 1];
        list_len--;
        return taken;
    endfunction

    function automatic list_result_t apply_list_op(input logic [OPC_W-1:0] opc,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic signed [WORD_W-1:0] word);
        list_result_t             res;
        int unsigned              k;
        logic signed [WORD_W-1:0] taken;
        res.word   = '0;
        res.status = ST_OK;
        case (opc)
            OP_APPEND:
                if (list_len >= LIST_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    list_words[list_len] = word;
                    list_len++;
                end
            OP_INSERT:
                if (list_len >= LIST_DEPTH)
                    res.status = ST_FULL;
                else if (pos > list_len)
                    res.status = ST_RANGE;
                else
                begin
                    for (k = list_len; k > pos; k--)
                        list_words[k] = list_words[k - 1];
                    list_words[pos] = word;
                    list_len++;
                end
            OP_REMOVE, OP_GET, OP_POP_AT:
                if (list_len == 0)
                    res.status = ST_EMPTY;
                else if (pos >= list_len)
                    res.status = ST_RANGE;
                else if (opc == OP_GET)
                    res.word = list_words[pos];
                else
                begin
                    taken = drop_entry(pos);
                    if (opc == OP_POP_AT)
                        res.word = taken;
                end
            OP_POP_LAST:
                if (list_len == 0)
                    res.status = ST_EMPTY;
                else
                    res.word = drop_entry(list_len - 1);
            default:
                ;
        endcase
        res.count = CNT_W'(list_len);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic send_item(input logic [OPC_W-1:0] opc, input logic [POS_W-1:0] pos,
                             input logic signed [WORD_W-1:0] word, input bit typed,
                             input list_result_t want);
        list_result_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.opcode   <= opc;
        req_ch.position <= pos;
        req_ch.word_in  <= word;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = apply_list_op(opc, pos, word);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_items(input int total);
        int                       i;
        int                       grow_pct;
        logic [OPC_W-1:0]         opc;
        logic [POS_W-1:0]         pos;
        logic signed [WORD_W-1:0] word;
        grow_pct = 50;
        for (i = 0; i < total; i++)
        begin
            // The list drifts toward full or empty in stretches, so both ends are visited often.
            if (i % 40 == 0)
                grow_pct = $urandom_range(85, 15);
            if ($urandom_range(99) < 3)
                opc = $urandom_range(1) ? OP_UNUSED_A : OP_UNUSED_B;
            else if ($urandom_range(99) < grow_pct)
                opc = $urandom_range(1) ? OP_APPEND : OP_INSERT;
            else
                case ($urandom_range(3))
                    0:       opc = OP_REMOVE;
                    1:       opc = OP_GET;
                    2:       opc = OP_POP_LAST;
                    default: opc = OP_POP_AT;
                endcase
            if ($urandom_range(99) < 20)
                pos = POS_W'($urandom_range(31));
            else if (opc == OP_INSERT)
                pos = POS_W'($urandom_range(list_len));
            else if (list_len == 0)
                pos = '0;
            else
                pos = POS_W'($urandom_range(list_len - 1));
            case ($urandom_range(19))
                0:       word = WORD_MIN;
                1:       word = WORD_MAX;
                2:       word = '0;
                3:       word = WORD_ONES;
                default: word = $urandom;
            endcase
            send_item(opc, pos, word, 1'b0, '0);
        end
    endtask

    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : response_check
        list_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected transaction word=%0d count=%0d status=%0d",
                                          rsp_ch.word_out, rsp_ch.count, rsp_ch.status));
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.word_out !== want.word)
                    report_mismatch($sformatf("word_out %0d, expected %0d",
                                              rsp_ch.word_out, want.word));
                if (rsp_ch.count !== want.count)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              rsp_ch.count, want.count));
                if (rsp_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %s",
                                              rsp_ch.status, want.status.name()));
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        int                       r;
        int                       n;
        int                       phase;
        logic signed [WORD_W-1:0] word;
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.opcode   <= '0;
        req_ch.position <= '0;
        req_ch.word_in  <= '0;
        src_idle_pct = 15;
        rcv_idle_pct = 86;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < $size(directed_rows); r++)
            for (n = 0; n < directed_rows[r].reps; n++)
            begin
                word = (directed_rows[r].reps > 1) ? $urandom : directed_rows[r].word;
                send_item(directed_rows[r].opc, directed_rows[r].pos, word,
                          directed_rows[r].typed, directed_rows[r].want);
            end

        for (phase = 0; phase < 3; phase++)
        begin
            hold_until_drained();
            src_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 86 : 0;
            rcv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 15 : 0;
            random_items(RANDOM_PER_PHASE);
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
src/isl_pkg.sv
src/isl_if.sv
src/isl_cell.sv
src/isl_ctrl.sv
src/indexed_shift_list.sv
bench/testbench.sv
